### src/iest_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event state tracker package
// Shared sizes, event kind codes and the event and result structures.
// ----------------------------------------------------------------------------
package iest_pkg;

    localparam int KEY_WORDS    = 7;
    localparam int BUTTON_COUNT = 16;

    localparam int KEY_WORD_W   = 32;
    localparam int WORD_IDX_W   = 3;
    localparam int IN_TDATA_W   = 40;
    localparam int IN_TUSER_W   = 9;
    localparam int OUT_TDATA_W  = 232;

    // Usages at and above this base are modifier keys.
    localparam logic [7:0] MOD_BASE = 8'hE0;

    localparam logic [7:0] KIND_KEY_DOWN = 8'd1;
    localparam logic [7:0] KIND_KEY_UP   = 8'd2;
    localparam logic [7:0] KIND_BTN_DOWN = 8'd3;
    localparam logic [7:0] KIND_BTN_UP   = 8'd4;
    localparam logic [7:0] KIND_ABSOLUTE = 8'd5;
    localparam logic [7:0] KIND_RELATIVE = 8'd6;

    localparam int SEEN_KEYBOARD = 0;
    localparam int SEEN_MOUSE    = 1;

    typedef logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] t_key_words;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  kind;
        logic [7:0]  code;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_event;

    typedef struct packed {
        logic [15:0]           mod_held;
        logic [15:0]           mod_pressed;
        logic [15:0]           mod_released;
        logic [15:0]           btn_held;
        logic [15:0]           btn_pressed;
        logic [15:0]           btn_released;
        logic signed [15:0]    delta_x;
        logic signed [15:0]    delta_y;
        logic [KEY_WORD_W-1:0] key_held_word;
        logic [KEY_WORD_W-1:0] key_pressed_word;
        logic [KEY_WORD_W-1:0] key_released_word;
        logic [1:0]            present_flags;
    } t_result;

endpackage

### src/iest_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event state tracker: state update
// Holds the key, modifier and button bitmaps, the motion accumulators and the
// presence flags, and shows the state as it stands after the current event.
// ----------------------------------------------------------------------------
module iest_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  iest_pkg::t_event i_event,
    output iest_pkg::t_result o_result
);

    iest_pkg::t_key_words r_keys_down, n_keys_down;
    iest_pkg::t_key_words r_keys_went_down, n_keys_went_down;
    iest_pkg::t_key_words r_keys_went_up, n_keys_went_up;
    logic [15:0] r_mods_down, n_mods_down;
    logic [15:0] r_mods_went_down, n_mods_went_down;
    logic [15:0] r_mods_went_up, n_mods_went_up;
    logic [15:0] r_btns_down, n_btns_down;
    logic [15:0] r_btns_went_down, n_btns_went_down;
    logic [15:0] r_btns_went_up, n_btns_went_up;
    logic [15:0] r_motion_x, n_motion_x;
    logic [15:0] r_motion_y, n_motion_y;
    logic [15:0] r_last_x, n_last_x;
    logic [15:0] r_last_y, n_last_y;
    logic        r_pos_known, n_pos_known;
    logic [1:0]  r_seen, n_seen;

    logic [iest_pkg::WORD_IDX_W-1:0] w_idx;
    logic                            w_is_mod;
    logic [15:0]                     w_mod_bit;
    logic [iest_pkg::KEY_WORD_W-1:0] w_key_bit;
    logic [15:0]                     w_btn_bit;
    logic [3:0]                      w_btn_num;

    assign w_idx     = i_event.code[7:5];
    assign w_is_mod  = (i_event.code >= iest_pkg::MOD_BASE);
    // Modifier usages from 0xf0 up have no bitmap bit.
    assign w_mod_bit = i_event.code[4] ? 16'd0 : (16'd1 << i_event.code[3:0]);
    assign w_key_bit = iest_pkg::KEY_WORD_W'(1) << i_event.code[4:0];
    assign w_btn_num = 4'(i_event.code - 8'd1);
    assign w_btn_bit = (i_event.code >= 8'd1 && i_event.code <= 8'(iest_pkg::BUTTON_COUNT))
                       ? (16'd1 << w_btn_num) : 16'd0;

    always_comb begin
        n_keys_down      = r_keys_down;
        n_keys_went_down = r_keys_went_down;
        n_keys_went_up   = r_keys_went_up;
        n_mods_down      = r_mods_down;
        n_mods_went_down = r_mods_went_down;
        n_mods_went_up   = r_mods_went_up;
        n_btns_down      = r_btns_down;
        n_btns_went_down = r_btns_went_down;
        n_btns_went_up   = r_btns_went_up;
        n_motion_x       = r_motion_x;
        n_motion_y       = r_motion_y;
        n_last_x         = r_last_x;
        n_last_y         = r_last_y;
        n_pos_known      = r_pos_known;
        n_seen           = r_seen;

        if (i_event.req_type) begin
            n_keys_went_down = '0;
            n_keys_went_up   = '0;
            n_mods_went_down = '0;
            n_mods_went_up   = '0;
            n_btns_went_down = '0;
            n_btns_went_up   = '0;
            n_motion_x       = '0;
            n_motion_y       = '0;
        end else begin
            case (i_event.kind)
                iest_pkg::KIND_KEY_DOWN: begin
                    n_seen[iest_pkg::SEEN_KEYBOARD] = 1'b1;
                    if (w_is_mod) begin
                        n_mods_down      = r_mods_down | w_mod_bit;
                        n_mods_went_down = r_mods_went_down | w_mod_bit;
                    end else begin
                        for (int w = 0; w < iest_pkg::KEY_WORDS; w++) begin
                            if (w_idx == iest_pkg::WORD_IDX_W'(w)) begin
                                n_keys_down[w]      = r_keys_down[w] | w_key_bit;
                                n_keys_went_down[w] = r_keys_went_down[w] | w_key_bit;
                            end
                        end
                    end
                end
                iest_pkg::KIND_KEY_UP: begin
                    n_seen[iest_pkg::SEEN_KEYBOARD] = 1'b1;
                    if (w_is_mod) begin
                        n_mods_down    = r_mods_down & ~w_mod_bit;
                        n_mods_went_up = r_mods_went_up | w_mod_bit;
                    end else begin
                        for (int w = 0; w < iest_pkg::KEY_WORDS; w++) begin
                            if (w_idx == iest_pkg::WORD_IDX_W'(w)) begin
                                n_keys_down[w]    = r_keys_down[w] & ~w_key_bit;
                                n_keys_went_up[w] = r_keys_went_up[w] | w_key_bit;
                            end
                        end
                    end
                end
                iest_pkg::KIND_BTN_DOWN: begin
                    n_seen[iest_pkg::SEEN_MOUSE] = 1'b1;
                    n_btns_down      = r_btns_down | w_btn_bit;
                    n_btns_went_down = r_btns_went_down | w_btn_bit;
                end
                iest_pkg::KIND_BTN_UP: begin
                    n_seen[iest_pkg::SEEN_MOUSE] = 1'b1;
                    n_btns_down    = r_btns_down & ~w_btn_bit;
                    n_btns_went_up = r_btns_went_up | w_btn_bit;
                end
                iest_pkg::KIND_ABSOLUTE: begin
                    n_seen[iest_pkg::SEEN_MOUSE] = 1'b1;
                    // The first known position only seeds the reference point.
                    if (r_pos_known) begin
                        n_motion_x = r_motion_x + (i_event.pos_x - r_last_x);
                        n_motion_y = r_motion_y + (i_event.pos_y - r_last_y);
                    end
                    n_last_x    = i_event.pos_x;
                    n_last_y    = i_event.pos_y;
                    n_pos_known = 1'b1;
                end
                iest_pkg::KIND_RELATIVE: begin
                    n_seen[iest_pkg::SEEN_MOUSE] = 1'b1;
                    n_motion_x = r_motion_x + i_event.pos_x;
                    n_motion_y = r_motion_y + i_event.pos_y;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_result                   = '0;
        o_result.mod_held          = n_mods_down;
        o_result.mod_pressed       = n_mods_went_down;
        o_result.mod_released      = n_mods_went_up;
        o_result.btn_held          = n_btns_down;
        o_result.btn_pressed       = n_btns_went_down;
        o_result.btn_released      = n_btns_went_up;
        o_result.delta_x           = n_motion_x;
        o_result.delta_y           = n_motion_y;
        o_result.present_flags     = n_seen;
        // Words past the last key word read as zero.
        for (int w = 0; w < iest_pkg::KEY_WORDS; w++) begin
            if (w_idx == iest_pkg::WORD_IDX_W'(w)) begin
                o_result.key_held_word     = n_keys_down[w];
                o_result.key_pressed_word  = n_keys_went_down[w];
                o_result.key_released_word = n_keys_went_up[w];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys_down      <= '0;
            r_keys_went_down <= '0;
            r_keys_went_up   <= '0;
            r_mods_down      <= '0;
            r_mods_went_down <= '0;
            r_mods_went_up   <= '0;
            r_btns_down      <= '0;
            r_btns_went_down <= '0;
            r_btns_went_up   <= '0;
            r_motion_x       <= '0;
            r_motion_y       <= '0;
            r_last_x         <= '0;
            r_last_y         <= '0;
            r_pos_known      <= 1'b0;
            r_seen           <= '0;
        end else if (i_step) begin
            r_keys_down      <= n_keys_down;
            r_keys_went_down <= n_keys_went_down;
            r_keys_went_up   <= n_keys_went_up;
            r_mods_down      <= n_mods_down;
            r_mods_went_down <= n_mods_went_down;
            r_mods_went_up   <= n_mods_went_up;
            r_btns_down      <= n_btns_down;
            r_btns_went_down <= n_btns_went_down;
            r_btns_went_up   <= n_btns_went_up;
            r_motion_x       <= n_motion_x;
            r_motion_y       <= n_motion_y;
            r_last_x         <= n_last_x;
            r_last_y         <= n_last_y;
            r_pos_known      <= n_pos_known;
            r_seen           <= n_seen;
        end
    end

endmodule

### src/input_event_state_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event state tracker
// Folds keyboard and mouse events into held, pressed and released bitmaps,
// motion deltas and presence flags, and returns one snapshot per event.
// ----------------------------------------------------------------------------
// The block takes one event request per clock while the output is not stalled
// and returns exactly one result per request: the request lands in an input
// register, and the state update and the result snapshot are computed from
// it and written to the state and the result register together. The 16-bit
// position difference followed by the 16-bit motion add of an absolute event
// sets the cycle. A request with req_type set starts a poll and clears the
// pressed and released bitmaps and the deltas; a request of an unknown kind
// only reads. The key word in the result is picked by code/32 and reads as
// zero past the last key word. There is no clearing pass: all state is valid
// as soon as reset is released.
module input_event_state_tracker_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // code[7:0], pos_x[23:8], pos_y[39:24]
    input  logic [iest_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // req_type[0], kind[8:1]
    input  logic [iest_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // mod_held[15:0], mod_pressed[31:16], mod_released[47:32],
    // btn_held[63:48], btn_pressed[79:64], btn_released[95:80],
    // delta_x[111:96], delta_y[127:112], key_held_word[159:128],
    // key_pressed_word[191:160], key_released_word[223:192],
    // present_flags[225:224], zero fill[231:226]
    output logic [iest_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    iest_pkg::t_event  w_event;
    iest_pkg::t_event  r_in;
    logic              r_in_valid;
    iest_pkg::t_result w_res;
    iest_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_out_free;
    logic              w_step;

    assign w_event.req_type = i_s_tuser[0];
    assign w_event.kind     = i_s_tuser[8:1];
    assign w_event.code     = i_s_tdata[7:0];
    assign w_event.pos_x    = i_s_tdata[23:8];
    assign w_event.pos_y    = i_s_tdata[39:24];

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_step;

    iest_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_event  (r_in),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= w_event;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0,
                         r_out.present_flags,
                         r_out.key_released_word,
                         r_out.key_pressed_word,
                         r_out.key_held_word,
                         r_out.delta_y,
                         r_out.delta_x,
                         r_out.btn_released,
                         r_out.btn_pressed,
                         r_out.btn_held,
                         r_out.mod_released,
                         r_out.mod_pressed,
                         r_out.mod_held};

`ifndef SYNTHESIS
    // An accepted request always occupies the input register next cycle.
    a_in_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_in_valid)
        else $error("accepted request did not reach the input register");

    // A new result only appears after a request was processed.
    a_out_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request");

    // A poll start shows cleared edge bitmaps and deltas.
    a_poll_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in.req_type) |=>
            (r_out.mod_pressed == 16'd0 && r_out.mod_released == 16'd0 &&
             r_out.btn_pressed == 16'd0 && r_out.btn_released == 16'd0 &&
             r_out.delta_x == 16'sd0 && r_out.delta_y == 16'sd0 &&
             r_out.key_pressed_word == '0 && r_out.key_released_word == '0))
        else $error("poll start did not clear edges and deltas");
`endif

endmodule

### tb/tb_input_event_state_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input event state tracker testbench
// Drives keyboard, mouse and poll requests into the tracker over the input
// stream, predicts every snapshot from a model of the held, pressed and
// released bitmaps, deltas and presence flags kept here, and checks each
// returned snapshot field by field under several patterns of idling and
// backpressure.
// ----------------------------------------------------------------------------
module tb_input_event_state_tracker_unit;

    localparam logic       REQ_EVENT         = 1'b0;
    localparam logic       REQ_POLL          = 1'b1;
    localparam logic [7:0] KIND_NONE         = 8'd0;
    localparam logic [7:0] KIND_FIRST_UNUSED = 8'd7;
    localparam logic [7:0] KIND_LAST_UNUSED  = 8'd255;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 420;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int BURST_REQUESTS   = 40;
    localparam int TAIL_CYCLES      = 8;

    // Folds each accepted request into its own copy of the tracker state and
    // keeps the resulting snapshots until the block returns them.
    class snapshot_tracker;
        bit [iest_pkg::KEY_WORD_W-1:0] keys_held     [iest_pkg::KEY_WORDS];
        bit [iest_pkg::KEY_WORD_W-1:0] keys_down_edge[iest_pkg::KEY_WORDS];
        bit [iest_pkg::KEY_WORD_W-1:0] keys_up_edge  [iest_pkg::KEY_WORDS];
        bit [15:0]           mods_held, mods_pressed, mods_released;
        bit [15:0]           btns_held, btns_pressed, btns_released;
        bit [15:0]           motion_x, motion_y, last_x, last_y;
        bit                  have_position;
        bit [1:0]            seen;
        iest_pkg::t_result   pending_snapshots[$];
        int                  mismatch_count;
        int                  snapshot_count;

        function void fold_event(iest_pkg::t_event ev);
            bit [15:0]         mask;
            bit [2:0]          word;
            bit                down;
            iest_pkg::t_result snap;
            word = ev.code[7:5];
            if (ev.req_type == REQ_POLL) begin
                foreach (keys_down_edge[i]) begin
                    keys_down_edge[i] = '0;
                    keys_up_edge[i]   = '0;
                end
                mods_pressed  = '0;
                mods_released = '0;
                btns_pressed  = '0;
                btns_released = '0;
                motion_x      = '0;
                motion_y      = '0;
            end else begin
                case (ev.kind)
                    iest_pkg::KIND_KEY_DOWN, iest_pkg::KIND_KEY_UP: begin
                        down = (ev.kind == iest_pkg::KIND_KEY_DOWN);
                        if (ev.code >= iest_pkg::MOD_BASE) begin
                            // Only the lower sixteen usages of the modifier range own a bit.
                            mask = ev.code[4] ? 16'h0000 : 16'h0001 << ev.code[3:0];
                            if (down) begin
                                mods_held    |= mask;
                                mods_pressed |= mask;
                            end else begin
                                mods_held     &= ~mask;
                                mods_released |= mask;
                            end
                        end else if (word < iest_pkg::KEY_WORDS) begin
                            if (down) begin
                                keys_held[word][ev.code[4:0]]      = 1'b1;
                                keys_down_edge[word][ev.code[4:0]] = 1'b1;
                            end else begin
                                keys_held[word][ev.code[4:0]]    = 1'b0;
                                keys_up_edge[word][ev.code[4:0]] = 1'b1;
                            end
                        end
                        seen[iest_pkg::SEEN_KEYBOARD] = 1'b1;
                    end
                    iest_pkg::KIND_BTN_DOWN, iest_pkg::KIND_BTN_UP: begin
                        mask = '0;
                        if (ev.code >= 1 && ev.code <= iest_pkg::BUTTON_COUNT) begin
                            mask[ev.code - 1] = 1'b1;
                        end
                        if (ev.kind == iest_pkg::KIND_BTN_DOWN) begin
                            btns_held    |= mask;
                            btns_pressed |= mask;
                        end else begin
                            btns_held     &= ~mask;
                            btns_released |= mask;
                        end
                        seen[iest_pkg::SEEN_MOUSE] = 1'b1;
                    end
                    iest_pkg::KIND_ABSOLUTE: begin
                        // The first absolute position after reset only sets the origin.
                        if (have_position) begin
                            motion_x += ev.pos_x - last_x;
                            motion_y += ev.pos_y - last_y;
                        end
                        last_x        = ev.pos_x;
                        last_y        = ev.pos_y;
                        have_position = 1'b1;
                        seen[iest_pkg::SEEN_MOUSE] = 1'b1;
                    end
                    iest_pkg::KIND_RELATIVE: begin
                        motion_x += ev.pos_x;
                        motion_y += ev.pos_y;
                        seen[iest_pkg::SEEN_MOUSE] = 1'b1;
                    end
                    default: ;
                endcase
            end

            snap.mod_held      = mods_held;
            snap.mod_pressed   = mods_pressed;
            snap.mod_released  = mods_released;
            snap.btn_held      = btns_held;
            snap.btn_pressed   = btns_pressed;
            snap.btn_released  = btns_released;
            snap.delta_x       = motion_x;
            snap.delta_y       = motion_y;
            snap.present_flags = seen;
            if (word < iest_pkg::KEY_WORDS) begin
                snap.key_held_word     = keys_held[word];
                snap.key_pressed_word  = keys_down_edge[word];
                snap.key_released_word = keys_up_edge[word];
            end else begin
                snap.key_held_word     = '0;
                snap.key_pressed_word  = '0;
                snap.key_released_word = '0;
            end
            pending_snapshots.push_back(snap);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %h, got %h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_snapshot(logic [iest_pkg::OUT_TDATA_W-1:0] bus);
            iest_pkg::t_result want;
            if (pending_snapshots.size() == 0) begin
                $error("snapshot returned with no request outstanding: %h", bus);
                mismatch_count++;
                return;
            end
            want = pending_snapshots.pop_front();
            snapshot_count++;
            compare_field("mod_held", want.mod_held, bus[15:0]);
            compare_field("mod_pressed", want.mod_pressed, bus[31:16]);
            compare_field("mod_released", want.mod_released, bus[47:32]);
            compare_field("btn_held", want.btn_held, bus[63:48]);
            compare_field("btn_pressed", want.btn_pressed, bus[79:64]);
            compare_field("btn_released", want.btn_released, bus[95:80]);
            compare_field("delta_x", 32'(unsigned'(want.delta_x)), bus[111:96]);
            compare_field("delta_y", 32'(unsigned'(want.delta_y)), bus[127:112]);
            compare_field("key_held_word", want.key_held_word, bus[159:128]);
            compare_field("key_pressed_word", want.key_pressed_word, bus[191:160]);
            compare_field("key_released_word", want.key_released_word, bus[223:192]);
            compare_field("present_flags", want.present_flags, bus[225:224]);
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n    = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    // code[7:0], pos_x[23:8], pos_y[39:24]
    logic [iest_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;
    // req_type[0], kind[8:1]
    logic [iest_pkg::IN_TUSER_W-1:0]  i_s_tuser  = '0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    // mod_held[15:0] ... present_flags[225:224], zero fill[231:226]
    logic [iest_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    snapshot_tracker board = new();
    int  sender_idle_pct    = 0;
    int  receiver_stall_pct = 0;
    logic hold_off          = 1'b0;
    int  cycle_count        = 0;
    int  request_count      = 0;

    input_event_state_tracker_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_input_event_state_tracker_unit: FAIL");
            $finish;
        end
    end

    // Output side: check what was taken at this edge, then choose the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            board.check_snapshot(o_m_tdata);
        end
        if (hold_off) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
        end
    end

    function automatic iest_pkg::t_event make_event(input logic req, input logic [7:0] kind,
                                                    input logic [7:0] code,
                                                    input logic [15:0] px,
                                                    input logic [15:0] py);
        iest_pkg::t_event ev;
        ev.req_type = req;
        ev.kind     = kind;
        ev.code     = code;
        ev.pos_x    = px;
        ev.pos_y    = py;
        return ev;
    endfunction

    // Mostly well-formed events on a small pool of keys and buttons so that
    // releases hit held bits; the rest is polls and kinds the block ignores.
    function automatic iest_pkg::t_event random_event();
        iest_pkg::t_event ev;
        int               pick;
        pick = $urandom_range(99, 0);
        ev = make_event(REQ_EVENT, 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                        16'($urandom), 16'($urandom));
        if (pick < 6) begin
            ev.req_type = REQ_POLL;
        end else if (pick >= 12) begin
            case ($urandom_range(5, 0))
                0: ev.kind = iest_pkg::KIND_KEY_DOWN;
                1: ev.kind = iest_pkg::KIND_KEY_UP;
                2: ev.kind = iest_pkg::KIND_BTN_DOWN;
                3: ev.kind = iest_pkg::KIND_BTN_UP;
                4: ev.kind = iest_pkg::KIND_ABSOLUTE;
                default: ev.kind = iest_pkg::KIND_RELATIVE;
            endcase
            if ((ev.kind == iest_pkg::KIND_KEY_DOWN || ev.kind == iest_pkg::KIND_KEY_UP) &&
                $urandom_range(1, 0)) begin
                ev.code = {3'($urandom_range(7, 0)), 5'($urandom_range(3, 0))};
            end
            if ((ev.kind == iest_pkg::KIND_BTN_DOWN || ev.kind == iest_pkg::KIND_BTN_UP) &&
                $urandom_range(3, 0) != 0) begin
                ev.code = 8'($urandom_range(17, 0));
            end
            if (ev.kind == iest_pkg::KIND_RELATIVE && $urandom_range(1, 0)) begin
                ev.pos_x = 16'($urandom_range(64, 0) - 32);
                ev.pos_y = 16'($urandom_range(64, 0) - 32);
            end
        end
        return ev;
    endfunction

    task automatic send_event(input iest_pkg::t_event ev);
        while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ev.pos_y, ev.pos_x, ev.code};
        i_s_tuser  <= {ev.kind, ev.req_type};
        do @(posedge i_clk); while (!o_s_tready);
        board.fold_event(ev);
        request_count++;
    endtask

    // Stop offering requests until every snapshot owed has come back.
    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending_snapshots.size() != 0);
    endtask

    initial begin
        int idle_plan [4];
        int stall_plan[4];
        idle_plan  = '{0, 84, 0, 27};
        stall_plan = '{0, 0, 84, 27};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: reset state, motion corners, key, modifier and
        // button edges, out-of-range codes, ignored kinds and polls.
        send_event(make_event(REQ_EVENT, KIND_NONE, 8'h00, 16'h0000, 16'h0000));
        send_event(make_event(REQ_POLL, KIND_NONE, 8'h00, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_ABSOLUTE, 8'h00, 16'h1234, 16'h5678));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_ABSOLUTE, 8'h00, 16'h0000, 16'hFFFF));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_RELATIVE, 8'h00, 16'h7FFF, 16'h8000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_DOWN, 8'h00, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_DOWN, 8'h1F, 16'hFFFF, 16'hFFFF));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_DOWN, 8'hDF, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_DOWN, 8'hDF, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_UP, 8'h1F, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_UP, 8'h55, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_DOWN, iest_pkg::MOD_BASE,
                              16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_DOWN, 8'hEF, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_UP, iest_pkg::MOD_BASE,
                              16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_DOWN, 8'hF0, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_KEY_UP, 8'hFF, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_BTN_DOWN, 8'd1, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_BTN_DOWN, 8'd16, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_BTN_DOWN, 8'd0, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_BTN_DOWN, 8'd17, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_BTN_UP, 8'd16, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, iest_pkg::KIND_BTN_UP, 8'd255, 16'h0000, 16'h0000));
        send_event(make_event(REQ_EVENT, KIND_FIRST_UNUSED, 8'hDF, 16'hFFFF, 16'hFFFF));
        send_event(make_event(REQ_EVENT, KIND_LAST_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF));
        send_event(make_event(REQ_POLL, iest_pkg::KIND_KEY_DOWN, 8'h00, 16'hFFFF, 16'hFFFF));
        send_event(make_event(REQ_EVENT, KIND_NONE, 8'hDF, 16'h0000, 16'h0000));
        wait_for_drain();

        // Keep the output stalled while requests pile up behind it.
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                repeat (BURST_REQUESTS) send_event(random_event());
            end
        join
        wait_for_drain();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = idle_plan[phase];
            receiver_stall_pct = stall_plan[phase];
            repeat (RANDOM_PER_PHASE) send_event(random_event());
            wait_for_drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d requests (directed, one stalled burst, four idling patterns).",
                 request_count);
        $display("Checked %0d snapshots, %0d field mismatches.",
                 board.snapshot_count, board.mismatch_count);
        if (board.mismatch_count == 0 && board.pending_snapshots.size() == 0) begin
            $display("tb_input_event_state_tracker_unit: PASS");
        end else begin
            $display("tb_input_event_state_tracker_unit: FAIL");
        end
        $finish;
    end

endmodule
